// ===== hw/rtl/pft_pkg.sv =====
// Package for the planar tile pixel fetch block.
// Holds store geometry, register indexes, field widths and shared types.
// No dependencies.
`default_nettype none

package pft_pkg;

	// Tile store geometry
	localparam int STORE_BYTES = 32768;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	// Wide enough for the largest fetch address plus the plane 1 offset
	localparam int FULL_W      = 21;

	// Field widths
	localparam int BYTE_ADDR_W = 15;
	localparam int PIX_W       = 10;
	localparam int RGBA_W      = 32;
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 40;
	localparam int CFG_IDX_W   = 3;

	// Tile geometry
	localparam int TILE_ROWS   = 8;
	localparam int PLANE_BYTES = 8;

	// Register reset values
	localparam logic [7:0]        TILES_ACROSS_RST = 8'd44;
	localparam logic [RGBA_W-1:0] COLOR_ZERO_RST   = 32'hFFFF_FFFF;
	localparam logic [RGBA_W-1:0] COLOR_ONE_RST    = 32'h0000_00FF;
	localparam logic [RGBA_W-1:0] COLOR_TWO_RST    = 32'h0000_0000;
	localparam logic [RGBA_W-1:0] COLOR_THREE_RST  = 32'h0000_0000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TWO_BIT_MODE = 3'd0,
		REG_TILES_ACROSS = 3'd1,
		REG_COLOR_ZERO   = 3'd2,
		REG_COLOR_ONE    = 3'd3,
		REG_COLOR_TWO    = 3'd4,
		REG_COLOR_THREE  = 3'd5
	} cfg_reg_t;

	// Item kinds on the input stream
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	// Palette, entry i is the color for index i
	typedef logic [3:0][RGBA_W-1:0] palette_t;

	// Address generator result for one fetch
	typedef struct packed {
		logic [ADDR_W-1:0] rd_addr0;
		logic [ADDR_W-1:0] rd_addr1;
		logic              beyond;
		logic [2:0]        bit_sel;
	} addr_info_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pft_addr_gen.sv =====
// Fetch address generator: pixel position to plane byte addresses.
// Depends on pft_pkg.
`default_nettype none

module pft_addr_gen
	import pft_pkg::*;
(
	input  wire logic [PIX_W-1:0] pixel_x,
	input  wire logic [PIX_W-1:0] pixel_y,
	input  wire logic             two_bit_mode,
	input  wire logic [7:0]       tiles_across,
	output addr_info_t            info
);

	logic [14:0]       tile_row;
	logic [15:0]       tile_num;
	logic [FULL_W-1:0] base;
	logic [FULL_W-1:0] addr0;
	logic [FULL_W-1:0] addr1;

	// Tile number from tile row and column, then scale by tile size
	always_comb begin
		tile_row = 15'(pixel_y[PIX_W-1:3]) * 15'(tiles_across);
		tile_num = 16'(tile_row) + 16'(pixel_x[PIX_W-1:3]);
		if (two_bit_mode) begin
			base = FULL_W'(tile_num) << 4;
		end else begin
			base = FULL_W'(tile_num) << 3;
		end
		addr0 = base + FULL_W'(pixel_y[2:0]);
		addr1 = addr0 + FULL_W'(PLANE_BYTES);
	end

	// Range check and bit select, leftmost pixel in bit 7
	always_comb begin
		info.rd_addr0 = addr0[ADDR_W-1:0];
		info.rd_addr1 = addr1[ADDR_W-1:0];
		info.beyond   = (addr0 >= FULL_W'(STORE_BYTES)) ||
		                (two_bit_mode && (addr1 >= FULL_W'(STORE_BYTES)));
		info.bit_sel  = ~pixel_x[2:0];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pft_tile_ram.sv =====
// Tile store: one write port and two read ports, read data registered.
// Depends on pft_pkg.
`default_nettype none

module pft_tile_ram
	import pft_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [7:0]        wr_data,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] rd_addr0,
	input  wire logic [ADDR_W-1:0] rd_addr1,
	output logic      [7:0]        rd_data0,
	output logic      [7:0]        rd_data1
);

	logic [7:0] mem [STORE_BYTES];

	// Store one byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read both planes, hold while stalled
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data0 <= mem[rd_addr0];
			rd_data1 <= mem[rd_addr1];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pft_pixel_sel.sv =====
// Pixel select: plane bits to color index and palette lookup.
// Depends on pft_pkg.
`default_nettype none

module pft_pixel_sel
	import pft_pkg::*;
(
	input  wire logic [7:0]        plane0,
	input  wire logic [7:0]        plane1,
	input  wire logic [2:0]        bit_sel,
	input  wire logic              two_bit_mode,
	input  wire logic              beyond,
	input  wire palette_t          palette,
	output logic      [1:0]        color_index,
	output logic      [RGBA_W-1:0] pixel_rgba
);

	logic lo_bit;
	logic hi_bit;

	// Pick the pixel bit from each plane, force index 0 when out of range
	always_comb begin
		lo_bit = plane0[bit_sel];
		hi_bit = two_bit_mode & plane1[bit_sel];
		if (beyond) begin
			color_index = 2'd0;
		end else begin
			color_index = {hi_bit, lo_bit};
		end
		pixel_rgba = palette[color_index];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/planar_tile_pixel_fetch.sv =====
// Planar tile pixel fetch, top level.
// Fetches pass stage 1, store read and output registers; write items give no result.
// Throughput: one item per cycle unless stalled, set by the two-read, one-write store.
// Reset: clears all valid flags and loads the register reset values; the tile store
// is not cleared and holds unknown bytes until written.
// Depends on pft_pkg, pft_addr_gen, pft_tile_ram and pft_pixel_sel.
`default_nettype none

module planar_tile_pixel_fetch
	import pft_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [RGBA_W-1:0]     cfg_data,
	// Input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// s_tdata: byte_address[14:0], byte_value[22:15], pixel_x[32:23], pixel_y[42:33], zero
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: op[0]
	input  wire logic                  s_tuser,
	// Result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// m_tdata: color_index[1:0], pixel_rgba[33:2], zero
	output logic      [OUT_DATA_W-1:0] m_tdata,
	// m_tuser: out_of_range[0]
	output logic                       m_tuser
);

	// Configuration registers
	logic        two_bit_mode_q;
	logic [7:0]  tiles_across_q;
	palette_t    palette_q;

	// Stage 1: accepted item
	logic                   valid_s1;
	logic                   op_s1;
	logic [BYTE_ADDR_W-1:0] byte_address_s1;
	logic [7:0]             byte_value_s1;
	logic [PIX_W-1:0]       pixel_x_s1;
	logic [PIX_W-1:0]       pixel_y_s1;

	// Stage 2: fetch with store data
	logic       valid_s2;
	logic       beyond_s2;
	logic [2:0] bit_sel_s2;
	logic [7:0] plane0_s2;
	logic [7:0] plane1_s2;

	// Output register
	logic              out_valid_q;
	logic [1:0]        color_index_q;
	logic [RGBA_W-1:0] pixel_rgba_q;
	logic              out_of_range_q;

	logic              ready_out;
	logic              ready_s2;
	logic              ready_s1;
	logic              adv_s1;
	logic              wr_en;
	logic [FULL_W-1:0] wr_full;
	addr_info_t        info;
	logic [1:0]        color_index;
	logic [RGBA_W-1:0] pixel_rgba;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_bit_mode_q <= 1'b0;
			tiles_across_q <= TILES_ACROSS_RST;
			palette_q[0]   <= COLOR_ZERO_RST;
			palette_q[1]   <= COLOR_ONE_RST;
			palette_q[2]   <= COLOR_TWO_RST;
			palette_q[3]   <= COLOR_THREE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TWO_BIT_MODE: two_bit_mode_q <= cfg_data[0];
				REG_TILES_ACROSS: tiles_across_q <= cfg_data[7:0];
				REG_COLOR_ZERO:   palette_q[0]   <= cfg_data;
				REG_COLOR_ONE:    palette_q[1]   <= cfg_data;
				REG_COLOR_TWO:    palette_q[2]   <= cfg_data;
				REG_COLOR_THREE:  palette_q[3]   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Per-stage flow control
	always_comb begin
		ready_out = !out_valid_q || m_tready;
		ready_s2  = !valid_s2 || ready_out;
		ready_s1  = !valid_s1 || ready_s2;
		adv_s1    = valid_s1 && ready_s2;
		s_tready  = ready_s1;
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			op_s1           <= s_tuser;
			byte_address_s1 <= s_tdata[14:0];
			byte_value_s1   <= s_tdata[22:15];
			pixel_x_s1      <= s_tdata[32:23];
			pixel_y_s1      <= s_tdata[42:33];
		end
	end

	pft_addr_gen u_addr_gen (
		.pixel_x      (pixel_x_s1),
		.pixel_y      (pixel_y_s1),
		.two_bit_mode (two_bit_mode_q),
		.tiles_across (tiles_across_q),
		.info         (info)
	);

	// Drop writes beyond the store
	always_comb begin
		wr_full = FULL_W'(byte_address_s1);
		wr_en   = adv_s1 && (op_s1 == OP_WRITE) && (wr_full < FULL_W'(STORE_BYTES));
	end

	pft_tile_ram u_tile_ram (
		.clk      (clk),
		.we       (wr_en),
		.wr_addr  (wr_full[ADDR_W-1:0]),
		.wr_data  (byte_value_s1),
		.re       (adv_s1),
		.rd_addr0 (info.rd_addr0),
		.rd_addr1 (info.rd_addr1),
		.rd_data0 (plane0_s2),
		.rd_data1 (plane1_s2)
	);

	// Stage 2 valid, fetch items only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1 && (op_s1 == OP_FETCH);
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			beyond_s2  <= info.beyond;
			bit_sel_s2 <= info.bit_sel;
		end
	end

	pft_pixel_sel u_pixel_sel (
		.plane0       (plane0_s2),
		.plane1       (plane1_s2),
		.bit_sel      (bit_sel_s2),
		.two_bit_mode (two_bit_mode_q),
		.beyond       (beyond_s2),
		.palette      (palette_q),
		.color_index  (color_index),
		.pixel_rgba   (pixel_rgba)
	);

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (ready_out && valid_s2) begin
			color_index_q  <= color_index;
			pixel_rgba_q   <= pixel_rgba;
			out_of_range_q <= beyond_s2;
		end
	end

	// Pack the result item
	always_comb begin
		m_tvalid = out_valid_q;
		m_tdata  = {{(OUT_DATA_W - RGBA_W - 2){1'b0}}, pixel_rgba_q, color_index_q};
		m_tuser  = out_of_range_q;
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for planar_tile_pixel_fetch: tile writes and pixel fetches
// over the stream ports, checked against a built-in predictor of the tile store.
// Depends on pft_pkg and the planar_tile_pixel_fetch RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pft_pkg::*;

	localparam int LATENCY     = 3;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	// One input item, unpacked
	typedef struct {
		op_t         op;
		logic [14:0] byte_address;
		logic [7:0]  byte_value;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
	} tile_item_t;

	// One fetch result
	typedef struct {
		logic [1:0]  color_index;
		logic [31:0] pixel_rgba;
		logic        out_of_range;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [RGBA_W-1:0]     cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// s_tdata: byte_address[14:0], byte_value[22:15], pixel_x[32:23], pixel_y[42:33], zero
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// s_tuser: op[0]
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// m_tdata: color_index[1:0], pixel_rgba[33:2], zero
	logic [OUT_DATA_W-1:0] m_tdata;
	// m_tuser: out_of_range[0]
	logic                  m_tuser;

	planar_tile_pixel_fetch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Predictor state: store contents and register copies
	logic [7:0]  tile_mem [STORE_BYTES];
	logic        two_planes   = 1'b0;
	logic [7:0]  tiles_across = TILES_ACROSS_RST;
	palette_t    palette      = {COLOR_THREE_RST, COLOR_TWO_RST, COLOR_ONE_RST, COLOR_ZERO_RST};

	// Stimulus bookkeeping: bytes queued for writing so far, in queue order
	bit          byte_known [STORE_BYTES];
	int          known_list [$];

	tile_item_t  pending_items [$];
	pixel_t      expected_pixels [$];
	tile_item_t  cur_item;
	pixel_t      want;
	pixel_t      head_pixel;

	bit          idle_on = 1'b1;
	bit          load_next;
	bit          next_valid;
	int          send_gap = 0;
	int          stall_left = 0;
	int          quiet = 0;
	int          phase_items = 0;
	int          n_writes = 0;
	int          n_fetches = 0;
	int          n_beyond = 0;
	int          n_checked = 0;
	int          n_bad = 0;
	int          n_settings = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Plane 0 byte address of a pixel under the current settings
	function automatic int fetch_addr(input logic [9:0] px, input logic [9:0] py);
		int xi, yi, ta;
		xi = int'(px);
		yi = int'(py);
		ta = int'(tiles_across);
		return (yi & 7) + ((xi >> 3) + (yi >> 3) * ta) * (two_planes ? 16 : 8);
	endfunction

	function automatic bit fetch_beyond(input int a);
		return (a >= STORE_BYTES) || (two_planes && (a + PLANE_BYTES >= STORE_BYTES));
	endfunction

	// Expected result of one fetch
	function automatic pixel_t predict_pixel(input tile_item_t it);
		pixel_t res;
		int     a, a1, sh;
		logic   lo, hi;
		a = fetch_addr(it.pixel_x, it.pixel_y);
		a1 = a + PLANE_BYTES;
		sh = 7 - int'(it.pixel_x[2:0]);
		res.out_of_range = fetch_beyond(a);
		if (res.out_of_range) begin
			res.color_index = 2'd0;
		end else begin
			lo = tile_mem[a[ADDR_W-1:0]][sh[2:0]];
			hi = two_planes ? tile_mem[a1[ADDR_W-1:0]][sh[2:0]] : 1'b0;
			res.color_index = {hi, lo};
		end
		res.pixel_rgba = palette[res.color_index];
		return res;
	endfunction

	// A fetch may only touch bytes already written, unless it lands beyond the store
	function automatic bit fetch_ready(input logic [9:0] px, input logic [9:0] py);
		int a, a1;
		a = fetch_addr(px, py);
		a1 = a + PLANE_BYTES;
		if (fetch_beyond(a))
			return 1'b1;
		return byte_known[a[ADDR_W-1:0]] && (!two_planes || byte_known[a1[ADDR_W-1:0]]);
	endfunction

	// Find a pixel position that reads the tile row holding byte a
	function automatic bit place_fetch(input int a, output logic [9:0] px,
			output logic [9:0] py);
		int span, t, row, p0, p1, tx, ty, ta;
		span = two_planes ? 16 : 8;
		ta = int'(tiles_across);
		t = a / span;
		row = a % 8;
		p0 = t * span + row;
		p1 = p0 + PLANE_BYTES;
		px = '0;
		py = '0;
		if (!byte_known[p0[ADDR_W-1:0]] || (two_planes && !byte_known[p1[ADDR_W-1:0]]))
			return 1'b0;
		if (ta == 0) begin
			if (t > 127)
				return 1'b0;
			tx = t;
			ty = $urandom_range(0, 127);
		end else begin
			tx = t % ta;
			ty = t / ta;
			if (ty > 127)
				return 1'b0;
		end
		px = 10'(tx * 8 + $urandom_range(0, 7));
		py = 10'(ty * 8 + row);
		return 1'b1;
	endfunction

	task automatic queue_write(input int a, input int v);
		tile_item_t it;
		it.op = OP_WRITE;
		it.byte_address = 15'(a);
		it.byte_value = 8'(v);
		it.pixel_x = 10'($urandom);
		it.pixel_y = 10'($urandom);
		pending_items.push_back(it);
		if (!byte_known[a[ADDR_W-1:0]]) begin
			byte_known[a[ADDR_W-1:0]] = 1'b1;
			known_list.push_back(a);
		end
		phase_items++;
	endtask

	task automatic queue_fetch(input logic [9:0] px, input logic [9:0] py);
		tile_item_t it;
		it.op = OP_FETCH;
		it.byte_address = 15'($urandom);
		it.byte_value = 8'($urandom);
		it.pixel_x = px;
		it.pixel_y = py;
		pending_items.push_back(it);
		phase_items++;
	endtask

	// Hold until the block is empty, then let in-flight writes settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_pixels.size() != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Called at a rising edge; the register takes the value at the next one
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_TWO_BIT_MODE: two_planes = val[0];
			REG_TILES_ACROSS: tiles_across = val[7:0];
			REG_COLOR_ZERO:   palette[0] = val;
			REG_COLOR_ONE:    palette[1] = val;
			REG_COLOR_TWO:    palette[2] = val;
			REG_COLOR_THREE:  palette[3] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(input bit mode, input logic [7:0] ta,
			input logic [31:0] c0, input logic [31:0] c1,
			input logic [31:0] c2, input logic [31:0] c3);
		wait_drained();
		write_reg(REG_TWO_BIT_MODE, {31'd0, mode});
		write_reg(REG_TILES_ACROSS, {24'd0, ta});
		write_reg(REG_COLOR_ZERO, c0);
		write_reg(REG_COLOR_ONE, c1);
		write_reg(REG_COLOR_TWO, c2);
		write_reg(REG_COLOR_THREE, c3);
		cfg_we <= 1'b0;
		@(negedge clk);
		n_settings++;
	endtask

	// Mostly whole tiles followed by fetches into them, plus scattered traffic
	task automatic gen_random_phase(input int target);
		int r, span, t_max, t, k, tries, ta;
		logic [9:0] x, y;
		phase_items = 0;
		while (phase_items < target) begin
			r = $urandom_range(0, 99);
			span = two_planes ? 16 : 8;
			ta = int'(tiles_across);
			if (r < 40) begin
				t_max = STORE_BYTES / span;
				if (ta == 0) begin
					if (t_max > 128)
						t_max = 128;
				end else if (t_max > 128 * ta) begin
					t_max = 128 * ta;
				end
				t = $urandom_range(0, t_max - 1);
				for (k = 0; k < span; k++)
					queue_write(t * span + k, $urandom_range(0, 255));
				k = $urandom_range(1, 6);
				repeat (k) begin
					if (place_fetch(t * span + $urandom_range(0, 7), x, y))
						queue_fetch(x, y);
				end
			end else if (r < 72) begin
				if (known_list.size() != 0 &&
						place_fetch(known_list[$urandom_range(0, known_list.size() - 1)], x, y))
					queue_fetch(x, y);
			end else if (r < 86) begin
				queue_write($urandom_range(0, STORE_BYTES - 1), $urandom_range(0, 255));
			end else begin
				for (tries = 0; tries < 4; tries++) begin
					x = 10'($urandom);
					y = 10'($urandom);
					if (fetch_ready(x, y)) begin
						queue_fetch(x, y);
						break;
					end
				end
			end
		end
	endtask

	// Driver: present queued items, apply each accepted one to the predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			send_gap = 0;
		end else begin
			load_next = !s_tvalid;
			if (s_tvalid && s_tready) begin
				load_next = 1'b1;
				if (cur_item.op == OP_WRITE) begin
					tile_mem[cur_item.byte_address] = cur_item.byte_value;
					n_writes++;
				end else begin
					want = predict_pixel(cur_item);
					expected_pixels.push_back(want);
					n_fetches++;
					if (want.out_of_range)
						n_beyond++;
				end
			end
			if (load_next) begin
				next_valid = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					s_tdata <= {5'd0, cur_item.pixel_y, cur_item.pixel_x,
						cur_item.byte_value, cur_item.byte_address};
					s_tuser <= cur_item.op;
					next_valid = 1'b1;
					if (idle_on && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 18);
				end
				s_tvalid <= next_valid;
			end
		end
	end

	// Monitor: check each result against the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					n_bad++;
					if (n_bad <= MAX_REPORTS)
						$display("tb_top: unexpected result idx=%0d rgba=%h oor=%b",
							m_tdata[1:0], m_tdata[33:2], m_tuser);
				end else begin
					head_pixel = expected_pixels.pop_front();
					n_checked++;
					if (m_tdata[1:0] !== head_pixel.color_index ||
							m_tdata[33:2] !== head_pixel.pixel_rgba ||
							m_tuser !== head_pixel.out_of_range) begin
						n_bad++;
						if (n_bad <= MAX_REPORTS)
							$display("tb_top: mismatch exp idx=%0d rgba=%h oor=%b, got idx=%0d rgba=%h oor=%b",
								head_pixel.color_index, head_pixel.pixel_rgba,
								head_pixel.out_of_range,
								m_tdata[1:0], m_tdata[33:2], m_tuser);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 17);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_top: no progress for %0d cycles", QUIET_LIMIT);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		bit mode;
		logic [7:0] ta;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: one plane, 44 tiles across, reset palette
		queue_write(0, 8'h80);
		queue_fetch(10'd0, 10'd0);
		queue_fetch(10'd1, 10'd0);
		queue_write(7, 8'h01);
		queue_fetch(10'd7, 10'd7);
		queue_write(STORE_BYTES - 1, 8'hFF);
		queue_fetch(10'd31, 10'd751);
		queue_fetch(10'd1023, 10'd1023);
		queue_write(0, 8'h00);
		queue_fetch(10'd0, 10'd0);

		// Two planes with zero tiles across: every tile row folds onto row zero
		apply_setting(1'b1, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h72DE_C2FF, 32'h6666_66FF);
		queue_write(16, 8'hC0);
		queue_write(24, 8'hA0);
		queue_fetch(10'd8, 10'd0);
		queue_fetch(10'd9, 10'd0);
		queue_fetch(10'd10, 10'd0);
		queue_fetch(10'd11, 10'd0);
		queue_fetch(10'd8, 10'd1016);
		queue_write(2039, 8'h01);
		queue_write(2047, 8'h01);
		queue_fetch(10'd1023, 10'd1023);

		// Random phases, extreme settings first
		for (ph = 0; ph < 8; ph++) begin
			mode = 1'($urandom_range(0, 1));
			ta = 8'($urandom_range(1, 128));
			case (ph)
				0: begin mode = 1'b0; ta = 8'd1; end
				1: begin mode = 1'b1; ta = 8'd128; end
				2: begin mode = 1'b0; ta = 8'd128; end
				3: begin mode = 1'b1; ta = 8'd1; end
				4: begin mode = 1'b0; ta = 8'd0; end
				default: ;
			endcase
			if (ph == 1)
				apply_setting(mode, ta, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
					32'hFFFF_FFFF);
			else
				apply_setting(mode, ta, $urandom, $urandom, $urandom, $urandom);
			idle_on = !(ph == 2 || ph >= 6);
			gen_random_phase(110);
		end

		wait_drained();
		repeat (LATENCY + 5) @(posedge clk);
		n_bad += expected_pixels.size();
		$display("tb_top: %0d items (%0d writes, %0d fetches, %0d beyond store) over %0d settings",
			n_writes + n_fetches, n_writes, n_fetches, n_beyond, n_settings + 1);
		$display("tb_top: %0d results checked, %0d failures", n_checked, n_bad);
		if (n_bad == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

// ===== planar_tile_pixel_fetch.f =====
hw/rtl/pft_pkg.sv
hw/rtl/pft_addr_gen.sv
hw/rtl/pft_tile_ram.sv
hw/rtl/pft_pixel_sel.sv
hw/rtl/planar_tile_pixel_fetch.sv
tb/sv/tb_top.sv
